FILE: hw/rtl/cca_pkg.sv
// ----------------------------------------------------------------------------
// cca_pkg
// Shared types and constants of the cross-correlation accumulator.
// ----------------------------------------------------------------------------
package cca_pkg;

    localparam int MAX_CHANNELS_DEF = 1024;
    localparam int ACC_BITS_DEF     = 48;

    localparam int SAMPLE_BITS    = 16;
    localparam int CH_BITS        = 10;
    localparam int CMD_BITS       = 2;
    localparam int CNT_BITS       = 16;
    localparam int NCH_BITS       = 11;
    localparam int CFG_BITS       = 16;
    localparam int CFG_IDX_BITS   = 2;
    localparam int VIS_BITS       = 33;
    localparam int POW_BITS       = 32;
    localparam int IN_TDATA_BITS  = 80;
    localparam int OUT_TDATA_BITS = 160;
    localparam int LANES          = 4;

    localparam logic [POW_BITS-1:0] POS_MAX   = 32'h7FFF_FFFF;
    localparam logic [POW_BITS-1:0] SAT_LIMIT = POS_MAX + 32'd1;
    localparam logic [CNT_BITS-1:0] COUNT_FULL = 16'hFFFF;
    localparam logic [NCH_BITS-1:0] NUM_CH_RESET = 11'd1024;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_ACC   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_NUM_CH      = 2'd0,
        REG_MAX_SPECTRA = 2'd1,
        REG_LSB_FIRST   = 2'd2,
        REG_LSB_SECOND  = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACC_RD,
        ST_ACC_SUM,
        ST_ACC_WR,
        ST_RD_RD,
        ST_RD_PREP,
        ST_RD_DIV,
        ST_RD_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic mem_rd;
        logic prod_en;
        logic sum_en;
        logic acc_wr;
        logic clr_wr;
        logic clr_count;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_ctrl;

    typedef struct packed {
        t_cmd cmd;
        logic acc_ok;
        logic no_data;
        logic clr_last;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

FILE: hw/rtl/cca_ctrl.sv
// ----------------------------------------------------------------------------
// cca_ctrl
// Sequencer for accumulate, read, clear and the clearing pass after reset.
// ----------------------------------------------------------------------------
module cca_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  cca_pkg::t_status i_status,
    output cca_pkg::t_ctrl   o_ctrl
);

    cca_pkg::t_state r_state;
    cca_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cca_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctrl     = '0;
        o_s_tready = 1'b0;
        case (r_state)
            cca_pkg::ST_CLEAR: begin
                o_ctrl.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = cca_pkg::ST_IDLE;
                end
            end
            cca_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_ctrl.capture = 1'b1;
                    case (i_status.cmd)
                        cca_pkg::CMD_ACC: begin
                            if (i_status.acc_ok) begin
                                n_state = cca_pkg::ST_ACC_RD;
                            end
                        end
                        cca_pkg::CMD_READ: begin
                            n_state = i_status.no_data ? cca_pkg::ST_RD_OUT
                                                       : cca_pkg::ST_RD_RD;
                        end
                        cca_pkg::CMD_CLEAR: begin
                            o_ctrl.clr_count = 1'b1;
                            n_state          = cca_pkg::ST_CLEAR;
                        end
                        default: begin
                            n_state = cca_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            cca_pkg::ST_ACC_RD: begin
                o_ctrl.mem_rd  = 1'b1;
                o_ctrl.prod_en = 1'b1;
                n_state        = cca_pkg::ST_ACC_SUM;
            end
            cca_pkg::ST_ACC_SUM: begin
                o_ctrl.sum_en = 1'b1;
                n_state       = cca_pkg::ST_ACC_WR;
            end
            cca_pkg::ST_ACC_WR: begin
                o_ctrl.acc_wr = 1'b1;
                n_state       = cca_pkg::ST_IDLE;
            end
            cca_pkg::ST_RD_RD: begin
                o_ctrl.mem_rd = 1'b1;
                n_state       = cca_pkg::ST_RD_PREP;
            end
            cca_pkg::ST_RD_PREP: begin
                o_ctrl.div_start = 1'b1;
                n_state          = cca_pkg::ST_RD_DIV;
            end
            cca_pkg::ST_RD_DIV: begin
                o_ctrl.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = cca_pkg::ST_RD_OUT;
                end
            end
            cca_pkg::ST_RD_OUT: begin
                if (i_status.out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state         = cca_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cca_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/cca_dp.sv
// ----------------------------------------------------------------------------
// cca_dp
// Datapath: configuration, accumulator memory, multipliers, divider lanes
// and the output register.
// ----------------------------------------------------------------------------
module cca_dp #(
    parameter int MAX_CHANNELS = cca_pkg::MAX_CHANNELS_DEF,
    parameter int ACC_BITS     = cca_pkg::ACC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cca_pkg::t_ctrl                      i_ctrl,
    output cca_pkg::t_status                    o_status,
    input  logic                                i_cfg_wr_en,
    input  logic [cca_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [cca_pkg::CFG_BITS-1:0]        i_cfg_data,
    input  logic [cca_pkg::IN_TDATA_BITS-1:0]   i_s_tdata,
    input  logic [cca_pkg::CMD_BITS-1:0]        i_s_tuser,
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [cca_pkg::OUT_TDATA_BITS-1:0]  o_m_tdata,
    output logic                                o_m_tuser
);

    localparam int AW    = $clog2(MAX_CHANNELS);
    localparam int DCW   = $clog2(ACC_BITS);
    localparam int SB    = cca_pkg::SAMPLE_BITS;
    localparam int CB    = cca_pkg::CNT_BITS;
    localparam int WB    = 4 * ACC_BITS;
    localparam int PB    = 2 * (SB + 1);
    localparam int TB    = PB + 1;
    localparam int PAD   = cca_pkg::OUT_TDATA_BITS - cca_pkg::CH_BITS - 2 * cca_pkg::VIS_BITS
                           - 2 * cca_pkg::POW_BITS - CB;

    // Configuration registers.
    logic [cca_pkg::NCH_BITS-1:0] r_num_ch;
    logic [CB-1:0]                r_max_sp;
    logic                         r_lsb_first;
    logic                         r_lsb_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ch     <= cca_pkg::NUM_CH_RESET;
            r_max_sp     <= '0;
            r_lsb_first  <= 1'b0;
            r_lsb_second <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (cca_pkg::t_reg_idx'(i_cfg_index))
                cca_pkg::REG_NUM_CH:      r_num_ch     <= i_cfg_data[cca_pkg::NCH_BITS-1:0];
                cca_pkg::REG_MAX_SPECTRA: r_max_sp     <= i_cfg_data[CB-1:0];
                cca_pkg::REG_LSB_FIRST:   r_lsb_first  <= i_cfg_data[0];
                cca_pkg::REG_LSB_SECOND:  r_lsb_second <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input fields.
    logic [cca_pkg::CH_BITS-1:0] w_ch;
    logic signed [SB:0]          w_ar;
    logic signed [SB:0]          w_ai;
    logic signed [SB:0]          w_br;
    logic signed [SB:0]          w_bi;
    logic [31:0]                 w_ch_ext;
    logic                        w_in_range;
    logic [CB-1:0]               w_limit;
    logic [CB-1:0]               r_count;

    assign w_ch     = i_s_tdata[9:0];
    assign w_ar     = (SB+1)'(signed'(i_s_tdata[25:10]));
    assign w_ai     = r_lsb_first ? -(SB+1)'(signed'(i_s_tdata[41:26]))
                                  : (SB+1)'(signed'(i_s_tdata[41:26]));
    assign w_br     = (SB+1)'(signed'(i_s_tdata[57:42]));
    assign w_bi     = r_lsb_second ? -(SB+1)'(signed'(i_s_tdata[73:58]))
                                   : (SB+1)'(signed'(i_s_tdata[73:58]));
    assign w_ch_ext = 32'(w_ch);
    assign w_in_range = (w_ch_ext < 32'(r_num_ch)) && (w_ch_ext < 32'(MAX_CHANNELS));
    assign w_limit  = (r_max_sp == '0) ? cca_pkg::COUNT_FULL : r_max_sp;

    // Captured item.
    logic [AW-1:0]      r_addr;
    logic signed [SB:0] r_ar;
    logic signed [SB:0] r_ai;
    logic signed [SB:0] r_br;
    logic signed [SB:0] r_bi;
    logic               r_eos;
    logic               r_nodata;
    logic [cca_pkg::CH_BITS-1:0] r_ch;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_ch     <= w_ch;
            r_addr   <= w_ch_ext[AW-1:0];
            r_ar     <= w_ar;
            r_ai     <= w_ai;
            r_br     <= w_br;
            r_bi     <= w_bi;
            r_eos    <= i_s_tlast;
            r_nodata <= (r_count == '0) || !w_in_range;
        end
    end

    // Products and sums.
    logic signed [PB-1:0] r_p_rr, r_p_ii, r_p_ir, r_p_ri;
    logic signed [PB-1:0] r_p_aa, r_p_ab, r_p_bb, r_p_bc;
    logic signed [TB-1:0] r_t_cr, r_t_ci, r_t_pf, r_t_ps;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.prod_en) begin
            r_p_rr <= r_ar * r_br;
            r_p_ii <= r_ai * r_bi;
            r_p_ir <= r_ai * r_br;
            r_p_ri <= r_ar * r_bi;
            r_p_aa <= r_ar * r_ar;
            r_p_ab <= r_ai * r_ai;
            r_p_bb <= r_br * r_br;
            r_p_bc <= r_bi * r_bi;
        end
        if (i_ctrl.sum_en) begin
            r_t_cr <= TB'(r_p_rr) + TB'(r_p_ii);
            r_t_ci <= TB'(r_p_ir) - TB'(r_p_ri);
            r_t_pf <= TB'(r_p_aa) + TB'(r_p_ab);
            r_t_ps <= TB'(r_p_bb) + TB'(r_p_bc);
        end
    end

    // Accumulator memory: one word holds the four sums of a channel.
    logic [WB-1:0] r_mem [MAX_CHANNELS];
    logic [WB-1:0] r_rdata;
    logic [WB-1:0] w_wdata;
    logic [AW-1:0] r_clr_addr;
    logic          w_clr_last;

    assign w_clr_last = (r_clr_addr == AW'(MAX_CHANNELS - 1));
    assign w_wdata = {
        r_rdata[4*ACC_BITS-1:3*ACC_BITS] + ACC_BITS'(r_t_ps),
        r_rdata[3*ACC_BITS-1:2*ACC_BITS] + ACC_BITS'(r_t_pf),
        r_rdata[2*ACC_BITS-1:ACC_BITS]   + ACC_BITS'(r_t_ci),
        r_rdata[ACC_BITS-1:0]            + ACC_BITS'(r_t_cr)
    };

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr_wr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_ctrl.acc_wr) begin
            r_mem[r_addr] <= w_wdata;
        end
        if (i_ctrl.mem_rd) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_ctrl.clr_wr) begin
            r_clr_addr <= w_clr_last ? '0 : r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.clr_count) begin
            r_count <= '0;
        end else if (i_ctrl.acc_wr && r_eos) begin
            r_count <= r_count + CB'(1);
        end
    end

    // Divider lanes: restoring division of each magnitude by the count.
    logic [ACC_BITS-1:0] r_quo [cca_pkg::LANES];
    logic [CB:0]         r_rem [cca_pkg::LANES];
    logic [ACC_BITS-1:0] n_quo [cca_pkg::LANES];
    logic [CB:0]         n_rem [cca_pkg::LANES];
    logic [ACC_BITS-1:0] w_dvd [cca_pkg::LANES];
    logic                r_neg_r;
    logic                r_neg_i;
    logic [DCW-1:0]      r_div_cnt;
    logic [CB:0]         w_shift;
    logic [CB:0]         w_divisor;

    assign w_divisor = {1'b0, r_count};
    assign w_dvd[0] = r_rdata[ACC_BITS-1] ? -r_rdata[ACC_BITS-1:0] : r_rdata[ACC_BITS-1:0];
    assign w_dvd[1] = r_rdata[2*ACC_BITS-1] ? -r_rdata[2*ACC_BITS-1:ACC_BITS]
                                            : r_rdata[2*ACC_BITS-1:ACC_BITS];
    assign w_dvd[2] = r_rdata[3*ACC_BITS-1:2*ACC_BITS];
    assign w_dvd[3] = r_rdata[4*ACC_BITS-1:3*ACC_BITS];

    always_comb begin
        w_shift = '0;
        for (int i = 0; i < cca_pkg::LANES; i++) begin
            w_shift  = {r_rem[i][CB-1:0], r_quo[i][ACC_BITS-1]};
            n_quo[i] = {r_quo[i][ACC_BITS-2:0], (w_shift >= w_divisor)};
            n_rem[i] = (w_shift >= w_divisor) ? w_shift - w_divisor : w_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.div_start) begin
            for (int i = 0; i < cca_pkg::LANES; i++) begin
                r_quo[i] <= w_dvd[i];
                r_rem[i] <= '0;
            end
            r_neg_r   <= r_rdata[ACC_BITS-1];
            r_neg_i   <= r_rdata[2*ACC_BITS-1];
            r_div_cnt <= '0;
        end else if (i_ctrl.div_step) begin
            for (int i = 0; i < cca_pkg::LANES; i++) begin
                r_quo[i] <= n_quo[i];
                r_rem[i] <= n_rem[i];
            end
            r_div_cnt <= r_div_cnt + DCW'(1);
        end
    end

    // Saturation and output register.
    logic [cca_pkg::POW_BITS-1:0] w_sat [cca_pkg::LANES];
    logic [cca_pkg::VIS_BITS-1:0] w_vis_r;
    logic [cca_pkg::VIS_BITS-1:0] w_vis_i;
    logic                         r_out_valid;
    logic [cca_pkg::OUT_TDATA_BITS-1:0] r_out_data;
    logic                         r_out_nodata;

    always_comb begin
        for (int i = 0; i < cca_pkg::LANES; i++) begin
            w_sat[i] = (r_quo[i] > ACC_BITS'(cca_pkg::SAT_LIMIT)) ? cca_pkg::SAT_LIMIT
                                                               : r_quo[i][cca_pkg::POW_BITS-1:0];
        end
    end

    assign w_vis_r = r_neg_r ? -{1'b0, w_sat[0]} : {1'b0, w_sat[0]};
    assign w_vis_i = r_neg_i ? -{1'b0, w_sat[1]} : {1'b0, w_sat[1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_out_nodata <= r_nodata;
            if (r_nodata) begin
                r_out_data <= {PAD'(0), r_count, 130'd0, r_ch};
            end else begin
                r_out_data <= {PAD'(0), r_count, w_sat[3], w_sat[2], w_vis_i, w_vis_r, r_ch};
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_nodata;

    assign o_status.cmd      = cca_pkg::t_cmd'(i_s_tuser);
    assign o_status.acc_ok   = w_in_range && (r_count < w_limit);
    assign o_status.no_data  = (r_count == '0) || !w_in_range;
    assign o_status.clr_last = w_clr_last;
    assign o_status.div_last = (r_div_cnt == DCW'(ACC_BITS - 1));
    assign o_status.out_free = !r_out_valid || i_m_tready;

endmodule

FILE: hw/rtl/cross_correlation_accumulator.sv
// ----------------------------------------------------------------------------
// cross_correlation_accumulator
// Per-channel cross-multiply-accumulate stage of an FX correlator.
// ----------------------------------------------------------------------------
// Items are taken one at a time. An accumulate item is accepted, then goes
// through a read-modify-write of the channel's word in the single-port
// accumulator memory with a multiply and a sum stage in between. A read
// with data passes through the bit-serial divider lanes that divide the
// four sums by the spectrum count; a read without data goes straight to the
// output register. Ignored items are dropped. After reset and after a clear
// command a clearing pass writes zero to all MAX_CHANNELS words, one per
// cycle, while no item is accepted; configuration writes are taken at any
// time. A waiting result does not stop accumulate or clear requests, but a
// read holds in its last cycle, and the input with it, until the output
// register is free.
module cross_correlation_accumulator #(
    parameter int MAX_CHANNELS = cca_pkg::MAX_CHANNELS_DEF,
    parameter int ACC_BITS     = cca_pkg::ACC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [cca_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [cca_pkg::CFG_BITS-1:0]       i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // channel, re_first, im_first, re_second, im_second, zero pad.
    input  logic [cca_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
    // command.
    input  logic [cca_pkg::CMD_BITS-1:0]       s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_channel, vis_real, vis_imag, auto_first, auto_second, spectra_done, zero pad.
    output logic [cca_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    // no_data.
    output logic                               m_axis_tuser
);

    cca_pkg::t_ctrl   w_ctrl;
    cca_pkg::t_status w_status;

    cca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl)
    );

    cca_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .ACC_BITS     (ACC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_status    (w_status),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_s_tlast   (s_axis_tlast),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );

endmodule

FILE: hw/rtl/cca_checker.sv
// ----------------------------------------------------------------------------
// cca_checker
// Port-level checks of the cross-correlation accumulator.
// ----------------------------------------------------------------------------
module cca_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [cca_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    input logic                               m_axis_tuser
);

    // The clearing pass follows every reset, so no request is taken.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready && !m_axis_tvalid)
        else $error("request taken or result shown right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_no_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[139:10] == 130'd0)
        else $error("averages not zero without data");

    a_power_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[107:76] <= cca_pkg::SAT_LIMIT
            && m_axis_tdata[139:108] <= cca_pkg::SAT_LIMIT)
        else $error("power average above saturation limit");

endmodule

bind cross_correlation_accumulator cca_checker u_cca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: bench/tb_cross_correlation_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cross_correlation_accumulator
// Checks the correlator's accumulate, read and clear requests against a
// behavioral model of the per-channel sums, under random stalls on both
// stream sides and several register settings.
// ----------------------------------------------------------------------------

class corr_scoreboard;
    logic [47:0] xr_sum [1024];
    logic [47:0] xi_sum [1024];
    logic [47:0] pa_sum [1024];
    logic [47:0] pb_sum [1024];
    logic [15:0] n_spectra;
    logic [10:0] n_chan;
    logic [15:0] spec_limit;
    logic        conj_a;
    logic        conj_b;
    logic [cca_pkg::OUT_TDATA_BITS:0] pending_reads [$];
    int errors;

    function void wipe();
        for (int k = 0; k < 1024; k++) begin
            xr_sum[k] = '0;
            xi_sum[k] = '0;
            pa_sum[k] = '0;
            pb_sum[k] = '0;
        end
        n_spectra = '0;
    endfunction

    function void reset_all();
        wipe();
        n_chan = cca_pkg::NUM_CH_RESET;
        spec_limit = '0;
        conj_a = 1'b0;
        conj_b = 1'b0;
        errors = 0;
    endfunction

    function void set_reg(cca_pkg::t_reg_idx idx, logic [15:0] val);
        case (idx)
            cca_pkg::REG_NUM_CH: n_chan = val[10:0];
            cca_pkg::REG_MAX_SPECTRA: spec_limit = val;
            cca_pkg::REG_LSB_FIRST: conj_a = val[0];
            cca_pkg::REG_LSB_SECOND: conj_b = val[0];
            default: ;
        endcase
    endfunction

    function logic signed [32:0] clip_vis(logic signed [47:0] q);
        if (q > 48'sd2147483648) return 33'sd2147483648;
        if (q < -48'sd2147483648) return -33'sd2147483648;
        return q[32:0];
    endfunction

    function void note_request(logic [1:0] cmd, logic [79:0] d, logic eos);
        logic [9:0] ch;
        logic ok;
        logic [15:0] lim;
        logic signed [17:0] ar, ai, br, bi;
        logic signed [47:0] tr, ti, ta, tb, n;
        logic [cca_pkg::OUT_TDATA_BITS:0] r;
        ch = d[9:0];
        ok = {1'b0, ch} < ((n_chan > 11'd1024) ? 11'd1024 : n_chan);
        lim = (spec_limit == 0) ? cca_pkg::COUNT_FULL : spec_limit;
        if (cmd == cca_pkg::CMD_ACC) begin
            if (n_spectra >= lim || !ok) return;
            ar = $signed(d[25:10]);
            ai = $signed(d[41:26]);
            br = $signed(d[57:42]);
            bi = $signed(d[73:58]);
            if (conj_a) ai = -ai;
            if (conj_b) bi = -bi;
            tr = ar * br + ai * bi;
            ti = ai * br - ar * bi;
            ta = ar * ar + ai * ai;
            tb = br * br + bi * bi;
            xr_sum[ch] += tr;
            xi_sum[ch] += ti;
            pa_sum[ch] += ta;
            pb_sum[ch] += tb;
            if (eos) n_spectra++;
        end else if (cmd == cca_pkg::CMD_CLEAR) begin
            wipe();
        end else if (cmd == cca_pkg::CMD_READ) begin
            r = '0;
            r[9:0] = ch;
            r[155:140] = n_spectra;
            if (n_spectra == 0 || !ok) begin
                r[cca_pkg::OUT_TDATA_BITS] = 1'b1;
            end else begin
                n = {32'd0, n_spectra};
                r[42:10] = clip_vis($signed(xr_sum[ch]) / n);
                r[75:43] = clip_vis($signed(xi_sum[ch]) / n);
                r[107:76] = ((pa_sum[ch] / n) > 48'd2147483648) ? cca_pkg::SAT_LIMIT
                            : 32'(pa_sum[ch] / n);
                r[139:108] = ((pb_sum[ch] / n) > 48'd2147483648) ? cca_pkg::SAT_LIMIT
                             : 32'(pb_sum[ch] / n);
                r[155:140] = n_spectra;
            end
            pending_reads.push_back(r);
        end
    endfunction

    function void check_result(logic [cca_pkg::OUT_TDATA_BITS-1:0] d, logic nd);
        logic [cca_pkg::OUT_TDATA_BITS:0] e;
        logic [cca_pkg::OUT_TDATA_BITS:0] a;
        if (pending_reads.size() == 0) begin
            $display("%0t unexpected result %h", $time, d);
            errors++;
            return;
        end
        e = pending_reads.pop_front();
        a = {nd, d};
        if (e[9:0] !== a[9:0])
            $display("%0t out_channel exp %h got %h", $time, e[9:0], a[9:0]);
        if (e[42:10] !== a[42:10])
            $display("%0t vis_real exp %h got %h", $time, e[42:10], a[42:10]);
        if (e[75:43] !== a[75:43])
            $display("%0t vis_imag exp %h got %h", $time, e[75:43], a[75:43]);
        if (e[107:76] !== a[107:76])
            $display("%0t auto_first exp %h got %h", $time, e[107:76], a[107:76]);
        if (e[139:108] !== a[139:108])
            $display("%0t auto_second exp %h got %h", $time, e[139:108], a[139:108]);
        if (e[155:140] !== a[155:140])
            $display("%0t spectra_done exp %h got %h", $time, e[155:140], a[155:140]);
        if (e[cca_pkg::OUT_TDATA_BITS] !== a[cca_pkg::OUT_TDATA_BITS])
            $display("%0t no_data exp %b got %b", $time, e[cca_pkg::OUT_TDATA_BITS],
                     a[cca_pkg::OUT_TDATA_BITS]);
        if (e !== a) errors++;
    endfunction
endclass

module tb_cross_correlation_accumulator;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [cca_pkg::CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [cca_pkg::CFG_BITS-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [cca_pkg::IN_TDATA_BITS-1:0] s_axis_tdata = '0;
    logic [cca_pkg::CMD_BITS-1:0] s_axis_tuser = '0;
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [cca_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic m_axis_tuser;

    corr_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off = 0;
    int quiet_cycles = 0;
    logic [10:0] cur_chan = 11'd1024;

    cross_correlation_accumulator DUT (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tuser, s_axis_tdata, s_axis_tlast);
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(cca_pkg::t_reg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_reg(idx, val);
        if (idx == cca_pkg::REG_NUM_CH) cur_chan = val[10:0];
    endtask

    task automatic send(cca_pkg::t_cmd cmd, logic [9:0] ch, logic [15:0] ar,
                        logic [15:0] ai, logic [15:0] br, logic [15:0] bi, logic eos);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {6'd0, bi, br, ai, ar, ch};
        s_axis_tlast <= eos;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_reads.size() != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
    endtask

    function automatic logic [15:0] sample();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int count);
        int lim;
        logic [9:0] ch;
        lim = (cur_chan == 0) ? 1 : ((cur_chan > 1024) ? 1024 : cur_chan);
        for (int k = 0; k < count; k++) begin
            ch = 10'(k % lim);
            case ($urandom_range(39))
                0: send(cca_pkg::CMD_CLEAR, 10'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 1'($urandom));
                1: send(cca_pkg::t_cmd'(2'd3), 10'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
                2, 3, 4, 5, 6:
                    send(cca_pkg::CMD_READ, ($urandom_range(9) == 0) ? 10'($urandom)
                         : 10'($urandom_range(lim - 1)), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), 1'($urandom));
                7: send(cca_pkg::CMD_ACC, 10'($urandom), sample(), sample(), sample(),
                        sample(), 1'($urandom));
                default: send(cca_pkg::CMD_ACC, ch, sample(), sample(), sample(), sample(),
                              (ch == lim - 1) || ($urandom_range(30) == 0));
            endcase
        end
    endtask

    initial begin
        sb.reset_all();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, all commands, conjugation, out-of-range reads.
        write_reg(cca_pkg::REG_NUM_CH, 16'd4);
        send(cca_pkg::CMD_READ, 10'd0, 0, 0, 0, 0, 0);
        send(cca_pkg::CMD_ACC, 10'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
        send(cca_pkg::CMD_ACC, 10'd1, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 0);
        send(cca_pkg::CMD_ACC, 10'd1023, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1);
        send(cca_pkg::CMD_ACC, 10'd3, 16'hFFFF, 16'h0001, 16'h0000, 16'hFFFF, 1);
        send(cca_pkg::CMD_READ, 10'd0, 0, 0, 0, 0, 0);
        send(cca_pkg::CMD_READ, 10'd1, 0, 0, 0, 0, 0);
        send(cca_pkg::CMD_READ, 10'd3, 0, 0, 0, 0, 0);
        send(cca_pkg::CMD_READ, 10'd1023, 0, 0, 0, 0, 0);
        send(cca_pkg::t_cmd'(2'd3), 10'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        drain();
        write_reg(cca_pkg::REG_LSB_FIRST, 16'd1);
        write_reg(cca_pkg::REG_LSB_SECOND, 16'd1);
        write_reg(cca_pkg::REG_MAX_SPECTRA, 16'd1);
        send(cca_pkg::CMD_ACC, 10'd2, 16'h8000, 16'h8000, 16'h1234, 16'h8000, 1);
        send(cca_pkg::CMD_ACC, 10'd2, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1);
        send(cca_pkg::CMD_READ, 10'd2, 0, 0, 0, 0, 0);
        send(cca_pkg::CMD_CLEAR, 10'd0, 0, 0, 0, 0, 0);
        send(cca_pkg::CMD_READ, 10'd2, 0, 0, 0, 0, 0);
        drain();
        write_reg(cca_pkg::REG_NUM_CH, 16'd0);
        send(cca_pkg::CMD_ACC, 10'd0, 16'h0100, 0, 16'h0100, 0, 1);
        send(cca_pkg::CMD_READ, 10'd0, 0, 0, 0, 0, 0);
        drain();

        // Random phases over several settings and idling mixes.
        write_reg(cca_pkg::REG_NUM_CH, 16'd8);
        write_reg(cca_pkg::REG_MAX_SPECTRA, 16'd0);
        write_reg(cca_pkg::REG_LSB_FIRST, 16'd0);
        write_reg(cca_pkg::REG_LSB_SECOND, 16'd1);
        send_idle_pct = 32;
        recv_idle_pct = 66;
        random_phase(400);
        drain();

        write_reg(cca_pkg::REG_NUM_CH, 16'd2047);
        write_reg(cca_pkg::REG_MAX_SPECTRA, 16'd65535);
        write_reg(cca_pkg::REG_LSB_FIRST, 16'd1);
        send_idle_pct = 66;
        recv_idle_pct = 32;
        random_phase(300);
        drain();

        write_reg(cca_pkg::REG_NUM_CH, 16'd1);
        write_reg(cca_pkg::REG_MAX_SPECTRA, 16'd5);
        write_reg(cca_pkg::REG_LSB_SECOND, 16'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(300);
        hold_off = 400;
        random_phase(100);
        drain();

        write_reg(cca_pkg::REG_NUM_CH, 16'd5);
        write_reg(cca_pkg::REG_MAX_SPECTRA, 16'd3);
        send_idle_pct = 10;
        recv_idle_pct = 10;
        random_phase(400);
        drain();

        if (sb.errors == 0 && sb.pending_reads.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/cca_pkg.sv
hw/rtl/cca_ctrl.sv
hw/rtl/cca_dp.sv
hw/rtl/cross_correlation_accumulator.sv
hw/rtl/cca_checker.sv
bench/tb_cross_correlation_accumulator.sv
